// File: hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants for the free block id allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int BLOCK_COUNT = 16384;

  localparam int ID_W      = 14;
  localparam int TOTAL_W   = 15;
  localparam int STATUS_W  = 2;
  localparam int OP_W      = 1;
  localparam int IN_DATA_W = ((ID_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_W + 7) / 8) * 8;

  localparam int ADDR_W  = $clog2(BLOCK_COUNT);
  localparam int DEPTH_W = $clog2(BLOCK_COUNT + 1);

  // fresh numbers stay below BLOCK_COUNT and the id width as well
  localparam int ID_SPAN   = 1 << ID_W;
  localparam int FRESH_CAP = (BLOCK_COUNT < ID_SPAN) ? BLOCK_COUNT : ID_SPAN;

  localparam int CFG_W     = TOTAL_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS     = 1'd1;

  localparam logic [ID_W-1:0]    RST_FIRST_DATA_BLOCK = 14'd1;
  localparam logic [TOTAL_W-1:0] RST_TOTAL_BLOCKS     = 15'd16384;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// File: hw/rtl/fba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/free_block_id_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// free_block_id_allocator
// Hands out free block numbers from a LIFO free list, then from a counter.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. A free, or an allocate
// served from the fresh counter or failing, goes straight to the output
// register; an allocate that pops the free list waits in S_POP for the
// registered read of the free-list RAM. A new request is taken only while
// the output register is empty or its response is transferred out in the
// same cycle. Writing either configuration register empties the free list
// and restarts the fresh counter at first_data_block; write only while no request is outstanding.
module free_block_id_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [fba_pkg::IN_DATA_W-1:0]   in_tdata,   // [13:0] block_number
  input  wire logic [fba_pkg::OP_W-1:0]        in_tuser,   // [0] opcode
  // response channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [fba_pkg::OUT_DATA_W-1:0]  out_tdata,  // [13:0] granted_block
  output logic      [fba_pkg::STATUS_W-1:0]    out_tuser,  // [1:0] status
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [fba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fba_pkg::CFG_W-1:0]       cfg_wdata
);
  import fba_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic                state_r, state_nxt;
  logic [ID_W-1:0]     first_r, first_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [TOTAL_W-1:0]  fresh_r, fresh_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;

  logic                in_acc;
  logic                is_alloc;
  logic                stack_empty;
  logic                stack_full;
  logic [TOTAL_W-1:0]  fresh_lim;
  logic                fresh_ok;
  logic                do_pop;
  logic                do_push;
  logic [DEPTH_W-1:0]  depth_dec;
  logic [ID_W-1:0]     rd_data;

  assign in_tready   = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc      = in_tvalid && in_tready;
  assign is_alloc    = (in_tuser == OP_ALLOC);
  assign stack_empty = (depth_r == '0);
  assign stack_full  = (depth_r == DEPTH_W'(BLOCK_COUNT));
  assign fresh_lim   = (total_r < TOTAL_W'(FRESH_CAP)) ? total_r : TOTAL_W'(FRESH_CAP);
  assign fresh_ok    = (fresh_r < fresh_lim);
  assign do_pop      = in_acc && is_alloc && !stack_empty;
  assign do_push     = in_acc && !is_alloc && !stack_full;
  assign depth_dec   = depth_r - DEPTH_W'(1);

  fba_ram #(
    .WIDTH (ID_W),
    .DEPTH (BLOCK_COUNT)
  ) u_stack (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (depth_r[ADDR_W-1:0]),
    .wr_data (in_tdata[ID_W-1:0]),
    .rd_en   (do_pop),
    .rd_addr (depth_dec[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    total_nxt     = total_r;
    depth_nxt     = depth_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;

    if (state_r == S_POP) begin
      // popped entry arrives from the RAM, output register is free here
      out_valid_nxt = 1'b1;
      out_id_nxt    = rd_data;
      out_st_nxt    = ST_OK;
      state_nxt     = S_IDLE;
    end

    if (in_acc) begin
      if (is_alloc) begin
        priority if (!stack_empty) begin
          depth_nxt = depth_dec;
          state_nxt = S_POP;
        end else if (fresh_ok) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = fresh_r[ID_W-1:0];
          out_st_nxt    = ST_OK;
          fresh_nxt     = fresh_r + TOTAL_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_st_nxt    = ST_EMPTY;
        end
      end else begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        if (stack_full) begin
          out_st_nxt = ST_FULL;
        end else begin
          out_st_nxt = ST_OK;
          depth_nxt  = depth_r + DEPTH_W'(1);
        end
      end
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_DATA_BLOCK: first_nxt = cfg_wdata[ID_W-1:0];
        REG_TOTAL_BLOCKS:     total_nxt = cfg_wdata;
        default: ;
      endcase
      depth_nxt = '0;
      fresh_nxt = TOTAL_W'(first_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= RST_FIRST_DATA_BLOCK;
      total_r     <= RST_TOTAL_BLOCKS;
      depth_r     <= '0;
      fresh_r     <= TOTAL_W'(RST_FIRST_DATA_BLOCK);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      total_r     <= total_nxt;
      depth_r     <= depth_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_id_r <= out_id_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_id_r);
  assign out_tuser  = out_st_r;

endmodule
`default_nettype wire

// File: hw/rtl/fba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks for the free block id allocator.
// ----------------------------------------------------------------------------
module fba_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [fba_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [fba_pkg::STATUS_W-1:0]    out_tuser
);
  import fba_pkg::*;

  // a stalled response holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("response changed while stalled");

  // only defined status codes leave the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_FULL))
    else $error("undefined status code");

  // failures and dropped frees carry no block number
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero block number on failure");

  // no response right after reset
  assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !out_tvalid)
    else $error("response valid right after reset");

  // a stalled response blocks new requests
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while response stalled");

endmodule

bind free_block_id_allocator fba_checker u_fba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
